// ===== hdl/atsd_pkg.sv =====
`default_nettype none
package atsd_pkg;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned IDX_W = 3;
	localparam int unsigned CFG_W = 16;

	localparam logic [IDX_W-1:0] REG_SHAKE_THR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TAP_THR     = 3'd1;
	localparam logic [IDX_W-1:0] REG_RELEASE_THR = 3'd2;
	localparam logic [IDX_W-1:0] REG_REFRACT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_TAP_WIN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DT_MIN      = 3'd5;
	localparam logic [IDX_W-1:0] REG_DT_MAX      = 3'd6;
	localparam logic [IDX_W-1:0] REG_SHAKE_N     = 3'd7;

	localparam logic [1:0] GC_TAP    = 2'd0;
	localparam logic [1:0] GC_DOUBLE = 2'd1;
	localparam logic [1:0] GC_SHAKE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic root_start;
		logic root_step;
		logic decide;
	} dp_cmd_t;

	typedef struct packed {
		logic over_range;
		logic root_done;
		logic has_result;
	} dp_stat_t;

	typedef struct packed {
		logic [15:0] shake_thr;
		logic [15:0] tap_thr;
		logic [15:0] release_thr;
		logic [15:0] refract;
		logic [15:0] tap_win;
		logic [15:0] dt_min;
		logic [15:0] dt_max;
		logic [7:0]  shake_n;
	} cfg_t;
endpackage
`default_nettype wire

// ===== hdl/atsd_if.sv =====
`default_nettype none
interface atsd_sample_if #(parameter int AXIS_BITS = 16);
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic [31:0] time_ms;
	logic double_tap_mode;
	modport source(output valid, accel_x, accel_y, accel_z, time_ms, double_tap_mode,
		input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, time_ms, double_tap_mode,
		output ready);
endinterface

interface atsd_gesture_if;
	logic valid;
	logic ready;
	logic [1:0] gesture_code;
	modport source(output valid, gesture_code, input ready);
	modport sink(input valid, gesture_code, output ready);
endinterface
`default_nettype wire

// ===== hdl/atsd_ctrl.sv =====
`default_nettype none
module atsd_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output atsd_pkg::dp_cmd_t cmd,
	input  wire atsd_pkg::dp_stat_t stat
);
	import atsd_pkg::*;
	state_t state_q, state_d;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_ROOT;
			ST_ROOT: begin
				if (stat.over_range) state_d = ST_IDLE;
				else if (stat.root_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = stat.has_result ? ST_OUT : ST_IDLE;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQUARE: cmd.square = 1'b1;
			ST_ROOT:   cmd.root_step = !stat.over_range && !stat.root_done;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default: ;
		endcase
		cmd.root_start = (state_q == ST_SQUARE);
	end
endmodule
`default_nettype wire

// ===== hdl/atsd_dp.sv =====
`default_nettype none
module atsd_dp #(parameter int AXIS_BITS = 16) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire atsd_pkg::cfg_t cfg,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic [31:0] time_ms,
	input  wire logic double_tap_mode,
	input  wire atsd_pkg::dp_cmd_t cmd,
	output atsd_pkg::dp_stat_t stat,
	output logic [1:0] gesture_code
);
	import atsd_pkg::*;
	localparam int SQ_W = 2 * AXIS_BITS;
	localparam int SUM_W = (SQ_W + 2 < 32) ? 32 : SQ_W + 2;

	logic [AXIS_BITS-1:0] ax_q, ay_q, az_q;
	logic [31:0] now_q;
	logic dtm_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0] rem_q;
	logic [31:0] res_q;
	logic [31:0] bit_q;
	logic [1:0] code_q;

	logic base_rdy_q, shake_rep_q, cand_q, pend_q, seen_q;
	logic [15:0] base_q, avg_q;
	logic [7:0] run_q;
	logic [31:0] tstart_q, ptime_q, lastg_q;

	function automatic logic [AXIS_BITS-1:0] mag_of(input logic [15:0] raw);
		logic [AXIS_BITS-1:0] v;
		v = AXIS_BITS'(raw);
		return v[AXIS_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	// sum of squares of the captured axes
	logic [SUM_W-1:0] sum_d;
	assign sum_d = SUM_W'({AXIS_BITS'(0), ax_q} * {AXIS_BITS'(0), ax_q})
		+ SUM_W'({AXIS_BITS'(0), ay_q} * {AXIS_BITS'(0), ay_q})
		+ SUM_W'({AXIS_BITS'(0), az_q} * {AXIS_BITS'(0), az_q});

	// capture sample and absolute axes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= mag_of(accel_x);
			ay_q <= mag_of(accel_y);
			az_q <= mag_of(accel_z);
			now_q <= time_ms;
			dtm_q <= double_tap_mode;
		end
		if (cmd.square)
			sum_q <= sum_d;
	end

	assign stat.over_range = (sum_q > SUM_W'(32'h4000_0000));
	assign stat.root_done = (bit_q == 32'd0);
	assign gesture_code = code_q;

	// iterative square root, one result bit per cycle, 16 steps from 2^30 down
	logic [31:0] trial;
	assign trial = res_q + bit_q;
	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rem_q <= sum_d[31:0];
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// gesture decision
	logic [15:0] mag, dev, avg_n, base_n;
	logic [7:0] run_n;
	logic refr, rep_n, cand_n, pend_n, seen_n, has_n;
	logic [31:0] ts_n, pt_n, lg_n;
	logic [1:0] code_n;
	logic [23:0] blend;
	logic [16:0] avg_sum;
	logic [8:0] run_inc;
	logic done;
	always_comb begin
		mag = res_q[15:0];
		refr = seen_q && ((now_q - lastg_q) < {16'd0, cfg.refract});
		dev = (mag >= base_q) ? mag - base_q : base_q - mag;
		avg_sum = {1'b0, dev} + {1'b0, avg_q};
		avg_n = avg_q; run_n = run_q; rep_n = shake_rep_q; cand_n = cand_q;
		pend_n = pend_q; seen_n = seen_q; ts_n = tstart_q; pt_n = ptime_q;
		lg_n = lastg_q; base_n = base_q; code_n = GC_TAP; has_n = 1'b0; done = 1'b0;
		run_inc = {1'b0, run_q} + 9'd1;
		blend = 24'(24'd243 * base_q) + 24'(24'd13 * mag) + 24'd128;
		if (pend_q && ((now_q - ptime_q) > {16'd0, cfg.dt_max})) begin
			pend_n = 1'b0;
			if (dtm_q && !refr) begin
				seen_n = 1'b1; lg_n = now_q; cand_n = 1'b0;
				code_n = GC_TAP; has_n = 1'b1; done = 1'b1;
			end
		end
		if (!done) begin
			avg_n = avg_sum[16:1];
			if (dev > cfg.shake_thr)
				run_n = (run_inc < {1'b0, cfg.shake_n}) ? run_inc[7:0] : cfg.shake_n;
			else begin
				run_n = 8'd0; rep_n = 1'b0;
			end
			if (avg_n > cfg.shake_thr && run_n >= cfg.shake_n && !rep_n) begin
				rep_n = 1'b1; cand_n = 1'b0; pend_n = 1'b0;
				if (!refr) begin
					seen_n = 1'b1; lg_n = now_q;
					code_n = GC_SHAKE; has_n = 1'b1; done = 1'b1;
				end
			end
		end
		if (!done) begin
			if (!cand_n && !refr && dev >= cfg.tap_thr) begin
				cand_n = 1'b1; ts_n = now_q;
			end
			if (cand_n) begin
				if ((now_q - ts_n) >= {16'd0, cfg.tap_win}) cand_n = 1'b0;
				else if (dev <= cfg.release_thr) begin
					cand_n = 1'b0;
					if (!dtm_q) begin
						seen_n = 1'b1; lg_n = now_q; pend_n = 1'b0;
						has_n = 1'b1; code_n = GC_TAP; done = 1'b1;
					end else if (pend_n && (now_q - ptime_q) >= {16'd0, cfg.dt_min}
						&& (now_q - ptime_q) <= {16'd0, cfg.dt_max}) begin
						seen_n = 1'b1; lg_n = now_q; pend_n = 1'b0;
						has_n = 1'b1; code_n = GC_DOUBLE; done = 1'b1;
					end else begin
						pend_n = 1'b1; pt_n = now_q;
					end
				end
			end
		end
		if (!done && !cand_n && !pend_n && dev < cfg.release_thr)
			base_n = blend[23:8];
		if (!base_rdy_q) begin
			base_n = mag; avg_n = 16'd0; has_n = 1'b0;
			run_n = run_q; rep_n = shake_rep_q; cand_n = cand_q; pend_n = pend_q;
			seen_n = seen_q; ts_n = tstart_q; pt_n = ptime_q; lg_n = lastg_q;
		end
	end

	assign stat.has_result = has_n;

	// hold gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rdy_q <= 1'b0; base_q <= 16'd2048; avg_q <= '0; run_q <= '0;
			shake_rep_q <= 1'b0; cand_q <= 1'b0; tstart_q <= '0; pend_q <= 1'b0;
			ptime_q <= '0; seen_q <= 1'b0; lastg_q <= '0;
			code_q <= GC_TAP;
		end else if (cmd.decide) begin
			base_rdy_q <= 1'b1; base_q <= base_n; avg_q <= avg_n; run_q <= run_n;
			shake_rep_q <= rep_n; cand_q <= cand_n; tstart_q <= ts_n; pend_q <= pend_n;
			ptime_q <= pt_n; seen_q <= seen_n; lastg_q <= lg_n;
			code_q <= code_n;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/accel_tap_shake_detector.sv =====
// Flow: an accepted sample goes through squaring (ST_SQUARE), the square root steps
// (ST_ROOT) and a decision (ST_DECIDE); a gesture then waits in ST_OUT until taken.
// A new sample is taken only in ST_IDLE, once the last one is through; an over-range
// sample returns to ST_IDLE from ST_ROOT with no root steps. A waiting result holds the input.
// Reset: arst_n asynchronous active low; control, configuration and gesture registers
// take their reset values, baseline waits for the first valid sample.
`default_nettype none
module accel_tap_shake_detector #(parameter int AXIS_BITS = 16) (
	input  wire logic clk,
	input  wire logic arst_n,
	atsd_sample_if.sink sample,
	atsd_gesture_if.source gesture,
	input  wire logic cfg_we,
	input  wire logic [atsd_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [atsd_pkg::CFG_W-1:0] cfg_data
);
	import atsd_pkg::*;
	cfg_t cfg_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd2048, 16'd3072, 16'd512, 16'd500, 16'd100, 16'd80, 16'd400, 8'd3};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHAKE_THR:   cfg_q.shake_thr <= cfg_data;
				REG_TAP_THR:     cfg_q.tap_thr <= cfg_data;
				REG_RELEASE_THR: cfg_q.release_thr <= cfg_data;
				REG_REFRACT:     cfg_q.refract <= cfg_data;
				REG_TAP_WIN:     cfg_q.tap_win <= cfg_data;
				REG_DT_MIN:      cfg_q.dt_min <= cfg_data;
				REG_DT_MAX:      cfg_q.dt_max <= cfg_data;
				REG_SHAKE_N:     cfg_q.shake_n <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	atsd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(sample.valid), .in_ready(sample.ready),
		.out_valid(gesture.valid), .out_ready(gesture.ready),
		.cmd, .stat
	);

	atsd_dp #(.AXIS_BITS(AXIS_BITS)) u_dp (
		.clk, .arst_n, .cfg(cfg_q),
		.accel_x(sample.accel_x), .accel_y(sample.accel_y), .accel_z(sample.accel_z),
		.time_ms(sample.time_ms), .double_tap_mode(sample.double_tap_mode),
		.cmd, .stat, .gesture_code(gesture.gesture_code)
	);
endmodule
`default_nettype wire

// ===== hdl/atsd_checker.sv =====
`default_nettype none
module atsd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] gesture_code
);
	import atsd_pkg::*;
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture_code == GC_TAP || gesture_code == GC_DOUBLE
			|| gesture_code == GC_SHAKE)) else $error("bad gesture code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gesture_code))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accepts while result waits");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind accel_tap_shake_detector atsd_checker u_chk (
	.clk, .arst_n,
	.in_valid(sample.valid), .in_ready(sample.ready),
	.out_valid(gesture.valid), .out_ready(gesture.ready),
	.gesture_code(gesture.gesture_code)
);
`default_nettype wire

// ===== tb/tb_accel_tap_shake_detector.sv =====
`default_nettype none
module tb_accel_tap_shake_detector;
	import atsd_pkg::*;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [31:0] t_ms;
		logic dt_mode;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	atsd_sample_if #(.AXIS_BITS(16)) smp();
	atsd_gesture_if gst();

	accel_tap_shake_detector #(.AXIS_BITS(16)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp),
		.gesture(gst),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stimulus and expected gestures
	sample_t sample_q[$];
	logic [1:0] gesture_q[$];
	sample_t cur;
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	bit hold_send = 1'b1;
	bit calm = 1'b0;
	bit fire;
	logic [1:0] code;
	logic [31:0] now_ms;

	// detector model state and register copy
	int unsigned cfg_reg [NUM_REGS];
	bit bl_ready, shake_rep, tap_cand, tap_pend, seen;
	int unsigned bl_level, avg, run_cnt, tap_t0, pend_t, last_t;

	function automatic int unsigned floor_sqrt(longint unsigned n);
		longint unsigned r = 0;
		longint unsigned trial;
		for (int b = 15; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= n)
				r = trial;
		end
		return int'(r);
	endfunction

	function automatic longint unsigned axis_mag(logic signed [15:0] v);
		longint signed w = v;
		return w < 0 ? -w : w;
	endfunction

	task automatic mark_gesture(int unsigned t);
		seen = 1'b1;
		last_t = t;
		tap_cand = 1'b0;
		tap_pend = 1'b0;
	endtask

	task automatic classify(input sample_t s, output bit hit, output logic [1:0] gc);
		longint unsigned ax, ay, az, sum;
		int unsigned mag, dev, t, n;
		bit refr;
		ax = axis_mag(s.ax);
		ay = axis_mag(s.ay);
		az = axis_mag(s.az);
		sum = ax * ax + ay * ay + az * az;
		t = s.t_ms;
		hit = 1'b0;
		gc = GC_TAP;
		if (sum > (64'd1 << 30))
			return;
		mag = floor_sqrt(sum);
		// first valid sample seeds the baseline
		if (!bl_ready) begin
			bl_level = mag;
			avg = 0;
			bl_ready = 1'b1;
			return;
		end
		refr = seen && ((t - last_t) < cfg_reg[REG_REFRACT]);
		// expire a waiting single tap
		if (tap_pend && (t - pend_t) > cfg_reg[REG_DT_MAX]) begin
			tap_pend = 1'b0;
			if (s.dt_mode && !refr) begin
				mark_gesture(t);
				hit = 1'b1;
				gc = GC_TAP;
				return;
			end
		end
		dev = mag >= bl_level ? mag - bl_level : bl_level - mag;
		avg = (dev + avg) >> 1;
		if (dev > cfg_reg[REG_SHAKE_THR]) begin
			n = run_cnt + 1;
			run_cnt = n < cfg_reg[REG_SHAKE_N] ? n : cfg_reg[REG_SHAKE_N];
		end else begin
			run_cnt = 0;
			shake_rep = 1'b0;
		end
		if (avg > cfg_reg[REG_SHAKE_THR] && run_cnt >= cfg_reg[REG_SHAKE_N] && !shake_rep) begin
			shake_rep = 1'b1;
			tap_cand = 1'b0;
			tap_pend = 1'b0;
			if (!refr) begin
				mark_gesture(t);
				hit = 1'b1;
				gc = GC_SHAKE;
				return;
			end
		end
		if (!tap_cand && !refr && dev >= cfg_reg[REG_TAP_THR]) begin
			tap_cand = 1'b1;
			tap_t0 = t;
		end
		if (tap_cand) begin
			if ((t - tap_t0) >= cfg_reg[REG_TAP_WIN]) begin
				tap_cand = 1'b0;
			end else if (dev <= cfg_reg[REG_RELEASE_THR]) begin
				tap_cand = 1'b0;
				if (!s.dt_mode) begin
					mark_gesture(t);
					hit = 1'b1;
					gc = GC_TAP;
					return;
				end
				if (tap_pend && (t - pend_t) >= cfg_reg[REG_DT_MIN] &&
						(t - pend_t) <= cfg_reg[REG_DT_MAX]) begin
					mark_gesture(t);
					hit = 1'b1;
					gc = GC_DOUBLE;
					return;
				end
				tap_pend = 1'b1;
				pend_t = t;
			end
		end
		// track the baseline only while quiet
		if (!tap_cand && !tap_pend && dev < cfg_reg[REG_RELEASE_THR])
			bl_level = (243 * bl_level + 13 * mag + 128) >> 8;
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready) begin
				classify(cur, fire, code);
				if (fire)
					gesture_q.push_back(code);
			end
			if (!smp.valid || smp.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					smp.valid <= 1'b0;
				end else if (sample_q.size() > 0 && !hold_send) begin
					cur = sample_q.pop_front();
					smp.accel_x <= cur.ax;
					smp.accel_y <= cur.ay;
					smp.accel_z <= cur.az;
					smp.time_ms <= cur.t_ms;
					smp.double_tap_mode <= cur.dt_mode;
					smp.valid <= 1'b1;
					if (!calm && $urandom_range(0, 15) == 0)
						gap_left = $urandom_range(1, 12);
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// gesture monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst.ready <= 1'b0;
		end else begin
			if (gst.valid && gst.ready) begin
				if (gesture_q.size() == 0) begin
					$display("%0t: unexpected gesture, expected none, actual %0d",
						$time, gst.gesture_code);
					fail_cnt++;
				end else begin
					code = gesture_q.pop_front();
					if (gst.gesture_code !== code) begin
						$display("%0t: gesture_code mismatch, expected %0d, actual %0d",
							$time, code, gst.gesture_code);
						fail_cnt++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				gst.ready <= 1'b0;
			end else begin
				gst.ready <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 1000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic add(int x, int y, int z, int unsigned step, bit dtm);
		sample_t s;
		now_ms += step;
		s.ax = 16'(x);
		s.ay = 16'(y);
		s.az = 16'(z);
		s.t_ms = now_ms;
		s.dt_mode = dtm;
		sample_q.push_back(s);
	endtask

	task automatic add_quiet(int unsigned n, int unsigned lo, int unsigned hi, bit dtm);
		repeat (n)
			add($urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
				2048 + $urandom_range(0, 80) - 40, $urandom_range(lo, hi), dtm);
	endtask

	task automatic add_tap(bit dtm);
		add($urandom_range(0, 400) - 200, 0, 2048 + $urandom_range(3000, 9000),
			$urandom_range(2, 15), dtm);
		if ($urandom_range(0, 5) == 0)
			add(0, 0, 2048 + $urandom_range(2000, 6000), $urandom_range(5, 60), dtm);
		add_quiet(1, 5, $urandom_range(0, 7) == 0 ? 160 : 40, dtm);
	endtask

	task automatic add_shake(bit dtm);
		int unsigned n;
		n = $urandom_range(2, 8);
		for (int i = 0; i < n; i++)
			add((i % 2 ? -1 : 1) * $urandom_range(6000, 20000), $urandom_range(0, 4000),
				2048, $urandom_range(5, 30), dtm);
	endtask

	task automatic add_mix(int unsigned n);
		int unsigned target;
		bit dtm;
		target = sample_q.size() + n;
		while (sample_q.size() < target) begin
			dtm = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1: add_quiet($urandom_range(1, 6), 5, 40, dtm);
				2, 3: add_tap(dtm);
				4, 5: begin
					add_tap(dtm);
					add_quiet($urandom_range(1, 4), 20, 110, dtm);
					add_tap(dtm);
				end
				6: add_shake(dtm);
				7: add_quiet(1, 300, 1200, dtm);
				8: add($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 20), dtm);
				default: begin
					sample_t s;
					s.ax = 16'($urandom_range(0, 65535));
					s.ay = 16'($urandom_range(0, 65535));
					s.az = 16'($urandom_range(0, 65535));
					s.t_ms = $urandom();
					s.dt_mode = dtm;
					now_ms = s.t_ms;
					sample_q.push_back(s);
				end
			endcase
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		cfg_reg[idx] = (idx == REG_SHAKE_N) ? (val & 8'hFF) : (val & 16'hFFFF);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int unsigned shake, int unsigned tap, int unsigned rel,
			int unsigned refract, int unsigned win, int unsigned dmin, int unsigned dmax,
			int unsigned cnt);
		write_reg(REG_SHAKE_THR, shake);
		write_reg(REG_TAP_THR, tap);
		write_reg(REG_RELEASE_THR, rel);
		write_reg(REG_REFRACT, refract);
		write_reg(REG_TAP_WIN, win);
		write_reg(REG_DT_MIN, dmin);
		write_reg(REG_DT_MAX, dmax);
		write_reg(REG_SHAKE_N, cnt);
	endtask

	// release queued samples and wait for every gesture to drain
	task automatic drain();
		hold_send = 1'b0;
		wait (sample_q.size() == 0 && !smp.valid && gesture_q.size() == 0);
		hold_send = 1'b1;
		repeat (30) @(posedge clk);
	endtask

	initial begin
		smp.valid = 1'b0;
		smp.accel_x = '0;
		smp.accel_y = '0;
		smp.accel_z = '0;
		smp.time_ms = '0;
		smp.double_tap_mode = 1'b0;
		gst.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_reg = '{2048, 3072, 512, 500, 100, 80, 400, 3};
		bl_ready = 0; bl_level = 2048; avg = 0; run_cnt = 0; shake_rep = 0;
		tap_cand = 0; tap_t0 = 0; tap_pend = 0; pend_t = 0; seen = 0; last_t = 0;
		now_ms = 32'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset settings, seed, range extremes, each gesture kind
		add(-32768, -32768, -32768, 1, 0);
		add(0, 0, 2048, 10, 0);
		add(32767, 0, 0, 10, 0);
		add_quiet(2, 600, 600, 0);
		add(-32768, 0, 0, 5, 0);
		add_quiet(2, 10, 10, 0);
		add_quiet(1, 600, 600, 0);
		add_tap(0);
		add_quiet(1, 600, 600, 1);
		add_tap(1);
		add_quiet(1, 100, 100, 1);
		add_tap(1);
		add_quiet(1, 600, 600, 1);
		add_tap(1);
		add_quiet(2, 300, 300, 1);
		add_quiet(1, 600, 600, 0);
		add_shake(0);
		drain();

		// defaults, with a full pause in the middle
		add_mix(300);
		drain();
		add_mix(250);
		drain();

		// lowest settings
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		add_mix(200);
		drain();

		// highest settings: nothing should trip
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255);
		add_mix(150);
		drain();

		// mid settings across the timestamp wrap
		write_all(32768, 32768, 32768, 200, 50, 20, 150, 1);
		now_ms = 32'hFFFF_F000;
		add_mix(200);
		drain();
		write_all($urandom_range(1000, 4000), $urandom_range(2000, 5000),
			$urandom_range(100, 1000), $urandom_range(50, 700), $urandom_range(30, 200),
			$urandom_range(10, 100), $urandom_range(150, 500), $urandom_range(1, 6));
		add_mix(400);
		drain();

		// back to reset values, no idling on either side
		write_all(2048, 3072, 512, 500, 100, 80, 400, 3);
		calm = 1'b1;
		add_mix(500);
		drain();

		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
